// ===== rtl/core/swap_slot_allocator_top_assert.svh =====
// assertion macros for the swap slot allocator
`ifndef SWAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define SWAP_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define SSA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ssa_pkg.sv =====
// shared constants, codes and control structs of the swap slot allocator
package ssa_pkg;

  localparam int MAX_SLOTS        = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  localparam int SLOT_W   = 10;
  localparam int TOP_W    = 11;
  localparam int SECTOR_W = 13;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 11;
  localparam int MUL_W    = SLOT_W + 7;

  localparam int MARK_W = 32;
  localparam int ROWS   = MAX_SLOTS / MARK_W;
  localparam int ROW_AW = $clog2(ROWS);
  localparam int BIT_AW = $clog2(MARK_W);

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;

  localparam logic REG_TOTAL_SLOTS = 1'b0;

  localparam logic [CFG_W-1:0] TOTAL_SLOTS_RST = CFG_W'(1024);

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  typedef struct packed {
    logic clr_wr;
    logic latch;
    logic row_load_zero;
    logic row_load_slot;
    logic row_inc;
    logic rd;
    logic take_free;
    logic take_top;
    logic bad_free;
    logic set_mark;
    logic trim_start;
    logic trim_step;
    logic load_out;
  } ssa_cmd_t;

  typedef struct packed {
    logic cmd_free;
    logic have_free;
    logic slot_ge_top;
    logic row_hit;
    logic mark_set;
    logic at_top;
    logic bit_zero;
    logic row_is_zero;
    logic trim_found;
    logic out_busy;
    logic clr_last;
  } ssa_stat_t;

endpackage

// ===== rtl/core/ssa_ram.sv =====
// generic single-write, single-read ram with registered read
module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ssa_ctrl.sv =====
// controller state machine of the swap slot allocator
`include "swap_slot_allocator_top_assert.svh"

module ssa_ctrl import ssa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  ssa_stat_t stat,
  output ssa_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_FREE_RD  = 4'd5;
  localparam logic [3:0] S_FREE_CHK = 4'd6;
  localparam logic [3:0] S_TRIM_RD  = 4'd7;
  localparam logic [3:0] S_TRIM_CHK = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.cmd_free) begin
          if (stat.have_free) begin
            cmd.row_load_zero = 1'b1;
            state_next        = S_SCAN_RD;
          end else begin
            cmd.take_top = 1'b1;
            state_next   = S_DONE;
          end
        end else if (stat.slot_ge_top) begin
          cmd.bad_free = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.row_load_slot = 1'b1;
          state_next        = S_FREE_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.row_hit) begin
          cmd.take_free = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.row_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_FREE_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (stat.mark_set) begin
          cmd.bad_free = 1'b1;
          state_next   = S_DONE;
        end else if (stat.at_top) begin
          cmd.trim_start = 1'b1;
          if (!stat.bit_zero) begin
            state_next = S_TRIM_CHK;
          end else if (stat.row_is_zero) begin
            state_next = S_DONE;
          end else begin
            state_next = S_TRIM_RD;
          end
        end else begin
          cmd.set_mark = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_TRIM_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_TRIM_CHK;
      end
      S_TRIM_CHK: begin
        cmd.trim_step = 1'b1;
        if (stat.trim_found || stat.row_is_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TRIM_RD;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `SSA_ASSERT_IMPLIES(a_scan_needs_free, clk, rst, state == S_SCAN_CHK, stat.have_free, "scan without free marks")
  `SSA_ASSERT_NEXT(a_accept_decodes, clk, rst, req_valid && req_ready, state == S_DECODE, "accepted word not decoded")
  `SSA_ASSERT_NEXT(a_done_returns, clk, rst, state == S_DONE && !stat.out_busy, state == S_IDLE, "result not handed off")

endmodule

// ===== rtl/core/ssa_dp.sv =====
// datapath of the swap slot allocator: free marks, high-water mark, result
`include "swap_slot_allocator_top_assert.svh"

module ssa_dp import ssa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ssa_cmd_t            cmd,
  output ssa_stat_t           stat,
  input  logic                command,
  input  logic [SLOT_W-1:0]   slot_index,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output logic [SLOT_W-1:0]   granted_slot,
  output logic [SECTOR_W-1:0] start_sector,
  output logic [STATUS_W-1:0] status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata
);

  function automatic logic [BIT_AW-1:0] lowest_set(input logic [MARK_W-1:0] v);
    logic [BIT_AW-1:0] r;
    r = '0;
    for (int i = MARK_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_AW'(i);
    end
    return r;
  endfunction

  function automatic logic [BIT_AW-1:0] highest_set(input logic [MARK_W-1:0] v);
    logic [BIT_AW-1:0] r;
    r = '0;
    for (int i = 0; i < MARK_W; i++) begin
      if (v[i]) r = BIT_AW'(i);
    end
    return r;
  endfunction

  function automatic logic [MARK_W-1:0] low_mask(input logic [BIT_AW-1:0] p);
    logic [MARK_W-1:0] m;
    for (int i = 0; i < MARK_W; i++) begin
      m[i] = (BIT_AW'(i) <= p);
    end
    return m;
  endfunction

  logic                cmd_free;
  logic [SLOT_W-1:0]   slot;
  logic [TOP_W-1:0]    top_slot;
  logic [TOP_W-1:0]    free_count;
  logic [CFG_W-1:0]    total_slots;
  logic [ROW_AW-1:0]   row;
  logic [BIT_AW-1:0]   pos;
  logic [ROW_AW-1:0]   clr_row;
  logic [SLOT_W-1:0]   res_slot;
  logic [STATUS_W-1:0] res_status;

  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr;
  logic [MARK_W-1:0]   ram_wdata;
  logic [MARK_W-1:0]   rdata;

  logic [BIT_AW-1:0]   bit_idx;
  logic [ROW_AW-1:0]   slot_row;
  logic [TOP_W-1:0]    slot_ext;
  logic [TOP_W-1:0]    limit;
  logic [BIT_AW-1:0]   low_bit;
  logic [MARK_W-1:0]   pos_mask;
  logic [MARK_W-1:0]   gap;
  logic                trim_found;
  logic [BIT_AW-1:0]   gap_top;
  logic [MARK_W-1:0]   gap_mask;
  logic [MUL_W-1:0]    sector_full;
  logic                cfg_wr;

  assign bit_idx    = slot[BIT_AW-1:0];
  assign slot_row   = slot[SLOT_W-1:BIT_AW];
  assign slot_ext   = TOP_W'(slot);
  assign limit      = (TOP_W'(total_slots) > TOP_W'(MAX_SLOTS)) ? TOP_W'(MAX_SLOTS)
                                                                 : TOP_W'(total_slots);
  assign low_bit    = lowest_set(rdata);
  assign pos_mask   = low_mask(pos);
  assign gap        = ~rdata & pos_mask;
  assign trim_found = |gap;
  assign gap_top    = highest_set(gap);
  assign gap_mask   = low_mask(gap_top);
  assign sector_full = MUL_W'(res_slot) * MUL_W'(SECTORS_PER_SLOT);

  assign cfg_wr = psel && penable && pwrite && (paddr[REG_IDX_LSB] == REG_TOTAL_SLOTS);
  assign prdata = (paddr[REG_IDX_LSB] == REG_TOTAL_SLOTS) ? PDATA_W'(total_slots) : '0;

  assign stat.cmd_free    = cmd_free;
  assign stat.have_free   = (free_count != '0);
  assign stat.slot_ge_top = (slot_ext >= top_slot);
  assign stat.row_hit     = |rdata;
  assign stat.mark_set    = rdata[bit_idx];
  assign stat.at_top      = ((slot_ext + TOP_W'(1)) == top_slot);
  assign stat.bit_zero    = (bit_idx == '0);
  assign stat.row_is_zero = (row == '0);
  assign stat.trim_found  = trim_found;
  assign stat.out_busy    = rsp_valid && !rsp_ready;
  assign stat.clr_last    = (clr_row == ROW_AW'(ROWS - 1));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = row;
    ram_wdata = rdata;
    priority if (cmd.clr_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_row;
      ram_wdata = '0;
    end else if (cmd.take_free) begin
      ram_we    = 1'b1;
      ram_wdata = rdata & ~(MARK_W'(1) << low_bit);
    end else if (cmd.set_mark) begin
      ram_we    = 1'b1;
      ram_wdata = rdata | (MARK_W'(1) << bit_idx);
    end else if (cmd.trim_step) begin
      ram_we    = 1'b1;
      ram_wdata = trim_found ? (rdata & ~(pos_mask & ~gap_mask)) : (rdata & ~pos_mask);
    end else begin
      ram_we = 1'b0;
    end
  end

  ssa_ram #(
    .WIDTH (MARK_W),
    .DEPTH (ROWS)
  ) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (row),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      top_slot    <= '0;
      free_count  <= '0;
      total_slots <= TOTAL_SLOTS_RST;
      clr_row     <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        total_slots <= pwdata[CFG_W-1:0];
      end
      if (cmd.clr_wr) begin
        clr_row <= clr_row + ROW_AW'(1);
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      priority if (cmd.take_top) begin
        if (top_slot < limit) begin
          top_slot <= top_slot + TOP_W'(1);
        end
      end else if (cmd.take_free) begin
        free_count <= free_count - TOP_W'(1);
      end else if (cmd.set_mark) begin
        free_count <= free_count + TOP_W'(1);
      end else if (cmd.trim_start) begin
        top_slot <= slot_ext;
      end else if (cmd.trim_step) begin
        if (trim_found) begin
          top_slot   <= TOP_W'({row, gap_top}) + TOP_W'(1);
          free_count <= free_count - TOP_W'(pos - gap_top);
        end else begin
          top_slot   <= TOP_W'({row, {BIT_AW{1'b0}}});
          free_count <= free_count - (TOP_W'(pos) + TOP_W'(1));
        end
      end else begin
        top_slot <= top_slot;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_free <= command;
      slot     <= slot_index;
    end
    priority if (cmd.row_load_zero) begin
      row <= '0;
    end else if (cmd.row_load_slot) begin
      row <= slot_row;
    end else if (cmd.row_inc) begin
      row <= row + ROW_AW'(1);
    end else if (cmd.trim_start) begin
      if (bit_idx == '0) begin
        row <= row - ROW_AW'(1);
        pos <= '1;
      end else begin
        pos <= bit_idx - BIT_AW'(1);
      end
    end else if (cmd.trim_step) begin
      if (!trim_found) begin
        row <= row - ROW_AW'(1);
        pos <= '1;
      end
    end else begin
      row <= row;
    end
    priority if (cmd.take_top) begin
      if (top_slot < limit) begin
        res_slot   <= top_slot[SLOT_W-1:0];
        res_status <= ST_OK;
      end else begin
        res_slot   <= '0;
        res_status <= ST_FULL;
      end
    end else if (cmd.take_free) begin
      res_slot   <= {row, low_bit};
      res_status <= ST_OK;
    end else if (cmd.bad_free) begin
      res_slot   <= slot;
      res_status <= ST_BAD_FREE;
    end else if (cmd.set_mark || cmd.trim_start) begin
      res_slot   <= slot;
      res_status <= ST_OK;
    end else begin
      res_slot <= res_slot;
    end
    if (cmd.load_out) begin
      granted_slot <= res_slot;
      start_sector <= sector_full[SECTOR_W-1:0];
      status       <= res_status;
    end
  end

  `SSA_ASSERT_IMPLIES(a_count_below_top, clk, rst, 1'b1, free_count <= top_slot, "more free marks than slots in use")
  `SSA_ASSERT_IMPLIES(a_top_in_range, clk, rst, 1'b1, top_slot <= TOP_W'(MAX_SLOTS), "high-water mark past the store")
  `SSA_ASSERT_IMPLIES(a_full_is_zero, clk, rst, rsp_valid && status == ST_FULL, granted_slot == '0 && start_sector == '0, "full word carries a slot")

endmodule

// ===== rtl/core/swap_slot_allocator_top.sv =====
// top level of the swap slot allocator
//
//   channel   direction  handshake                      payload
//   req       in         req_valid / req_ready          command, slot_index
//   rsp       out        rsp_valid / rsp_ready          granted_slot, start_sector, status
//   apb       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one word at a time; allocate from the mark or a free at or above it needs no mark read
// allocate reusing a freed slot reads and checks rows of 32 slot marks from row 0 on until
// one holds a free mark; other free reads the slot's row and sets its mark, or for the slot
// just below the mark lowers the mark past the free marks beneath it, row by row; the mark
// ram reads and writes one row per cycle; after reset a clearing pass runs over the mark
// ram with req_ready low; a new word is taken while the last result waits on rsp_ready
module swap_slot_allocator_top import ssa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic                command,
  input  logic [SLOT_W-1:0]   slot_index,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [SLOT_W-1:0]   granted_slot,
  output logic [SECTOR_W-1:0] start_sector,
  output logic [STATUS_W-1:0] status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  ssa_cmd_t  cmd;
  ssa_stat_t stat;

  assign pready = 1'b1;

  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (command),
    .slot_index   (slot_index),
    .rsp_ready    (rsp_ready),
    .rsp_valid    (rsp_valid),
    .granted_slot (granted_slot),
    .start_sector (start_sector),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
  );

endmodule
